// ===== rtl/core/edc_pkg.sv =====
// Shared types and constants for the elastic disc collision block.
// Depends on nothing; used by edc_core and elastic_disc_collision.
package edc_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned NumStages  = 65;

  typedef struct packed {
    logic signed [ValueWidth-1:0] first_pos_x;
    logic signed [ValueWidth-1:0] first_pos_y;
    logic signed [ValueWidth-1:0] second_pos_x;
    logic signed [ValueWidth-1:0] second_pos_y;
    logic signed [ValueWidth-1:0] first_vel_x;
    logic signed [ValueWidth-1:0] first_vel_y;
    logic signed [ValueWidth-1:0] second_vel_x;
    logic signed [ValueWidth-1:0] second_vel_y;
    logic        [ValueWidth-1:0] first_mass;
    logic        [ValueWidth-1:0] second_mass;
  } in_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] first_new_vel_x;
    logic signed [ValueWidth-1:0] first_new_vel_y;
    logic signed [ValueWidth-1:0] second_new_vel_x;
    logic signed [ValueWidth-1:0] second_new_vel_y;
    logic                         centers_coincide;
    logic                         saturated;
  } out_t;

endpackage

// ===== rtl/core/edc_core.sv =====
// Datapath pipeline of the collision response: normalize, square root,
// unit divide, mass divide, projections and saturation. Uses edc_pkg.
module edc_core import edc_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  in_t  in_data_i,
  output out_t out_data_o
);

  localparam int unsigned UnitQ    = 28;
  localparam int unsigned MassQ    = 30;
  localparam int unsigned SqrtBase = 5;
  localparam int unsigned UDivBase = 29;
  localparam int unsigned MDivBase = 3;
  localparam int unsigned MDivLast = 33;

  typedef struct packed {
    in_t                 d;
    logic                same;
    logic                sx;
    logic                sy;
    logic signed  [32:0] dvx;
    logic signed  [32:0] dvy;
    logic         [32:0] ax;
    logic         [32:0] ay;
    logic         [22:0] nx;
    logic         [22:0] ny;
    logic         [45:0] sqx;
    logic         [45:0] sqy;
    logic         [47:0] rad;
    logic         [25:0] srem;
    logic         [23:0] sroot;
    logic         [23:0] rx;
    logic         [23:0] ry;
    logic         [28:0] ux;
    logic         [28:0] uy;
    logic         [32:0] msum;
    logic         [32:0] mr1;
    logic         [32:0] mr2;
    logic         [30:0] f1;
    logic         [30:0] f2;
    logic signed  [29:0] usx;
    logic signed  [29:0] usy;
    logic signed  [62:0] px;
    logic signed  [62:0] py;
    logic signed  [34:0] w;
    logic signed  [66:0] wf1;
    logic signed  [66:0] wf2;
    logic signed  [35:0] j1;
    logic signed  [35:0] j2;
    logic signed  [65:0] pa;
    logic signed  [65:0] pb;
    logic signed  [65:0] pc;
    logic signed  [65:0] pd;
    out_t                o;
  } stage_t;

  // shift right, rounding the magnitude down
  function automatic logic signed [67:0] tzs(input logic signed [67:0] x, input int s);
    logic signed [67:0] bias;
    bias = x[67] ? ((68'sd1 <<< s) - 68'sd1) : 68'sd0;
    return (x + bias) >>> s;
  endfunction

  // {saturated, clamped value}
  function automatic logic [32:0] clamp(input logic signed [37:0] r);
    logic [32:0] res;
    if (r > 38'sd2147483647) begin
      res = {1'b1, 32'h7fff_ffff};
    end else if (r < -38'sd2147483648) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, r[31:0]};
    end
    return res;
  endfunction

  function automatic stage_t step(input stage_t s, input int k);
    stage_t              n;
    logic signed  [32:0] dx;
    logic signed  [32:0] dy;
    logic         [32:0] big;
    logic         [5:0]  p;
    logic         [32:0] tx;
    logic         [32:0] ty;
    logic         [27:0] rt;
    logic         [27:0] trial;
    logic         [24:0] rtx;
    logic         [24:0] rty;
    logic         [33:0] rm1;
    logic         [33:0] rm2;
    logic signed  [63:0] dot;
    logic signed  [37:0] r0;
    logic signed  [37:0] r1;
    logic signed  [37:0] r2;
    logic signed  [37:0] r3;
    logic         [32:0] c0;
    logic         [32:0] c1;
    logic         [32:0] c2;
    logic         [32:0] c3;
    n = s;
    if (k == 1) begin
      dx = 33'(s.d.first_pos_x) - 33'(s.d.second_pos_x);
      dy = 33'(s.d.first_pos_y) - 33'(s.d.second_pos_y);
      n.sx   = dx[32];
      n.sy   = dy[32];
      n.ax   = dx[32] ? 33'(-dx) : 33'(dx);
      n.ay   = dy[32] ? 33'(-dy) : 33'(dy);
      n.same = (dx == 33'sd0) && (dy == 33'sd0);
      n.dvx  = 33'(s.d.first_vel_x) - 33'(s.d.second_vel_x);
      n.dvy  = 33'(s.d.first_vel_y) - 33'(s.d.second_vel_y);
      n.msum = {1'b0, s.d.first_mass} + {1'b0, s.d.second_mass};
      n.mr1  = {1'b0, s.d.first_mass};
      n.mr2  = {1'b0, s.d.second_mass};
      n.f1   = '0;
      n.f2   = '0;
    end
    if (k == 2) begin
      big = (s.ax > s.ay) ? s.ax : s.ay;
      p = '0;
      for (int i = 0; i < 33; i++) begin
        if (big[i]) p = 6'(i);
      end
      if (p > 6'd22) begin
        tx = s.ax >> (p - 6'd22);
        ty = s.ay >> (p - 6'd22);
      end else begin
        tx = s.ax << (6'd22 - p);
        ty = s.ay << (6'd22 - p);
      end
      n.nx = tx[22:0];
      n.ny = ty[22:0];
    end
    if (k == 3) begin
      n.sqx = 46'(s.nx) * 46'(s.nx);
      n.sqy = 46'(s.ny) * 46'(s.ny);
    end
    if (k == 4) begin
      n.rad   = {1'b0, 47'(s.sqx) + 47'(s.sqy)};
      n.srem  = '0;
      n.sroot = '0;
    end
    if (k >= SqrtBase && k < UDivBase) begin
      rt    = {s.srem, s.rad[47:46]};
      trial = {2'b00, s.sroot, 2'b01};
      n.rad = {s.rad[45:0], 2'b00};
      if (rt >= trial) begin
        n.srem  = 26'(rt - trial);
        n.sroot = {s.sroot[22:0], 1'b1};
      end else begin
        n.srem  = rt[25:0];
        n.sroot = {s.sroot[22:0], 1'b0};
      end
    end
    if (k >= UDivBase && k < UDivBase + UnitQ + 1) begin
      if (k == UDivBase) begin
        rtx = {2'b00, s.nx};
        rty = {2'b00, s.ny};
        n.ux = '0;
        n.uy = '0;
      end else begin
        rtx = {s.rx, 1'b0};
        rty = {s.ry, 1'b0};
      end
      if (rtx >= {1'b0, s.sroot}) begin
        n.rx = 24'(rtx - {1'b0, s.sroot});
        n.ux = {(k == UDivBase) ? 28'd0 : s.ux[27:0], 1'b1};
      end else begin
        n.rx = rtx[23:0];
        n.ux = {(k == UDivBase) ? 28'd0 : s.ux[27:0], 1'b0};
      end
      if (rty >= {1'b0, s.sroot}) begin
        n.ry = 24'(rty - {1'b0, s.sroot});
        n.uy = {(k == UDivBase) ? 28'd0 : s.uy[27:0], 1'b1};
      end else begin
        n.ry = rty[23:0];
        n.uy = {(k == UDivBase) ? 28'd0 : s.uy[27:0], 1'b0};
      end
    end
    if (k >= MDivBase && k <= MDivLast) begin
      rm1 = (k == MDivBase) ? {1'b0, s.mr1} : {s.mr1, 1'b0};
      rm2 = (k == MDivBase) ? {1'b0, s.mr2} : {s.mr2, 1'b0};
      if (rm1 >= {1'b0, s.msum}) begin
        n.mr1 = 33'(rm1 - {1'b0, s.msum});
        n.f1  = {s.f1[29:0], 1'b1};
      end else begin
        n.mr1 = rm1[32:0];
        n.f1  = {s.f1[29:0], 1'b0};
      end
      if (rm2 >= {1'b0, s.msum}) begin
        n.mr2 = 33'(rm2 - {1'b0, s.msum});
        n.f2  = {s.f2[29:0], 1'b1};
      end else begin
        n.mr2 = rm2[32:0];
        n.f2  = {s.f2[29:0], 1'b0};
      end
      if (k == MDivLast && s.msum == '0) begin
        n.f1 = 31'(1) << (MassQ - 1);
        n.f2 = 31'(1) << (MassQ - 1);
      end
    end
    if (k == UDivBase + UnitQ + 1) begin
      n.usx = s.sx ? -$signed({1'b0, s.ux}) : $signed({1'b0, s.ux});
      n.usy = s.sy ? -$signed({1'b0, s.uy}) : $signed({1'b0, s.uy});
    end
    if (k == UDivBase + UnitQ + 2) begin
      n.px = 63'(s.dvx) * 63'(s.usx);
      n.py = 63'(s.dvy) * 63'(s.usy);
    end
    if (k == UDivBase + UnitQ + 3) begin
      dot = 64'(s.px) + 64'(s.py);
      n.w = 35'(tzs(68'(dot), UnitQ));
    end
    if (k == UDivBase + UnitQ + 4) begin
      n.wf1 = 67'(s.w) * 67'($signed({1'b0, s.f1}));
      n.wf2 = 67'(s.w) * 67'($signed({1'b0, s.f2}));
    end
    if (k == UDivBase + UnitQ + 5) begin
      n.j1 = 36'(tzs(68'(s.wf2), MassQ - 1));
      n.j2 = 36'(tzs(68'(s.wf1), MassQ - 1));
    end
    if (k == UDivBase + UnitQ + 6) begin
      n.pa = 66'(s.j1) * 66'(s.usx);
      n.pb = 66'(s.j1) * 66'(s.usy);
      n.pc = 66'(s.j2) * 66'(s.usx);
      n.pd = 66'(s.j2) * 66'(s.usy);
    end
    if (k == UDivBase + UnitQ + 7) begin
      r0 = 38'(s.d.first_vel_x)  - 38'(tzs(68'(s.pa), UnitQ));
      r1 = 38'(s.d.first_vel_y)  - 38'(tzs(68'(s.pb), UnitQ));
      r2 = 38'(s.d.second_vel_x) + 38'(tzs(68'(s.pc), UnitQ));
      r3 = 38'(s.d.second_vel_y) + 38'(tzs(68'(s.pd), UnitQ));
      c0 = clamp(r0);
      c1 = clamp(r1);
      c2 = clamp(r2);
      c3 = clamp(r3);
      if (s.same) begin
        n.o.first_new_vel_x  = s.d.first_vel_x;
        n.o.first_new_vel_y  = s.d.first_vel_y;
        n.o.second_new_vel_x = s.d.second_vel_x;
        n.o.second_new_vel_y = s.d.second_vel_y;
        n.o.saturated        = 1'b0;
      end else begin
        n.o.first_new_vel_x  = $signed(c0[31:0]);
        n.o.first_new_vel_y  = $signed(c1[31:0]);
        n.o.second_new_vel_x = $signed(c2[31:0]);
        n.o.second_new_vel_y = $signed(c3[31:0]);
        n.o.saturated        = c0[32] | c1[32] | c2[32] | c3[32];
      end
      n.o.centers_coincide = s.same;
    end
    return n;
  endfunction

  stage_t entry_d;
  stage_t pipe_q [NumStages];

  always_comb begin
    entry_d   = '0;
    entry_d.d = in_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= entry_d;
    end
  end

  for (genvar k = 1; k < NumStages; k++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pipe_q[k] <= step(pipe_q[k-1], k);
      end
    end
  end

  assign out_data_o = pipe_q[NumStages-1].o;

endmodule

// ===== rtl/core/elastic_disc_collision.sv =====
// Top level of the elastic disc collision block: handshake and valid
// chain around the edc_core datapath. Uses edc_pkg.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries one pair of
//   discs per transaction (centers, velocities, masses). Output channel
//   out_valid_o / out_stall_i / out_data_o returns one transaction with
//   both new velocities and the coincide and saturation flags.
//   A transaction is taken at an edge with valid high and stall low.
//   The pipeline runs 24 square-root stages and 29 unit-divide stages, one
//   result bit each, with the mass divide alongside. Throughput is one
//   transaction per cycle while out_stall_i does not freeze the pipeline.
//   Reset clears every valid bit; the datapath registers are not reset.
//   While the output holds a transaction and out_stall_i is high, the whole
//   pipeline freezes and in_stall_o rises; nothing is lost or repeated.
//   Empty slots do not hold the pipeline, so a stall only costs when the
//   output register is full.
module elastic_disc_collision import edc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic [NumStages-1:0] vld_q;
  logic                 adv;

  assign adv        = !(vld_q[NumStages-1] && out_stall_i);
  assign in_stall_o = !adv;
  assign out_valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  edc_core u_core (
    .clk_i      (clk_i),
    .en_i       (adv),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule
